FILE: rtl/core/soa_pkg.sv
// Shared types and constants for the oldest-stamp slot allocator.
package soa_pkg;

    localparam int FRAME_W        = 16;  // s_frame_id / m_evicted_frame port width
    localparam int SLOT_W         = 4;   // m_slot port width
    localparam int STAMP_W        = 32;
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int FRAME_BITS_DEF = 16;

    localparam logic [STAMP_W-1:0] STAMP_RESET = STAMP_W'(1);
    localparam logic [STAMP_W-1:0] STAMP_INCR  = STAMP_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_OUT    = 5'b10000
    } soa_state_t;

    // Sequencer controls for the scan unit
    typedef struct packed {
        logic clear;   // new transaction: drop previous search results
        logic sample;  // registered slot read is valid this cycle
    } soa_scan_ctl_t;

endpackage

FILE: rtl/core/soa_scan.sv
// Shared compare unit: one slot per cycle, tracks first tag match and oldest stamp.
module soa_scan #(
    parameter int NUM_SLOTS  = soa_pkg::NUM_SLOTS_DEF,
    parameter int FRAME_BITS = soa_pkg::FRAME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  soa_pkg::soa_scan_ctl_t        ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0]  rd_idx,
    input  logic                          rd_vld,
    input  logic [FRAME_BITS-1:0]         rd_tag,
    input  logic [soa_pkg::STAMP_W-1:0]   rd_stamp,
    input  logic [FRAME_BITS-1:0]         key,
    output logic                          found,
    output logic [$clog2(NUM_SLOTS)-1:0]  hit_idx,
    output logic [$clog2(NUM_SLOTS)-1:0]  best_idx,
    output logic                          best_vld,
    output logic [FRAME_BITS-1:0]         best_tag
);
    import soa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic                  found_reg,    found_next;
    logic [IDX_W-1:0]      hit_idx_reg,  hit_idx_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic                  best_vld_reg, best_vld_next;
    logic [FRAME_BITS-1:0] best_tag_reg, best_tag_next;
    logic [STAMP_W-1:0]    best_stp_reg, best_stp_next;
    logic [STAMP_W-1:0]    stamp_eff;
    logic                  is_match;

    // unowned slots read as stamp zero
    assign stamp_eff = rd_vld ? rd_stamp : '0;
    assign is_match  = rd_vld && (rd_tag == key);

    always_comb begin
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        best_idx_next = best_idx_reg;
        best_vld_next = best_vld_reg;
        best_tag_next = best_tag_reg;
        best_stp_next = best_stp_reg;
        priority if (ctl.clear) begin
            found_next = 1'b0;
        end else if (ctl.sample) begin
            if (is_match && !found_reg) begin
                found_next   = 1'b1;
                hit_idx_next = rd_idx;
            end
            // strict less-than keeps the lowest index on ties
            if ((rd_idx == '0) || (stamp_eff < best_stp_reg)) begin
                best_idx_next = rd_idx;
                best_vld_next = rd_vld;
                best_tag_next = rd_tag;
                best_stp_next = stamp_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        hit_idx_reg  <= hit_idx_next;
        best_idx_reg <= best_idx_next;
        best_vld_reg <= best_vld_next;
        best_tag_reg <= best_tag_next;
        best_stp_reg <= best_stp_next;
    end

    assign found    = found_reg;
    assign hit_idx  = hit_idx_reg;
    assign best_idx = best_idx_reg;
    assign best_vld = best_vld_reg;
    assign best_tag = best_tag_reg;

endmodule

FILE: rtl/core/slot_allocator_oldest_stamp_top.sv
// Top level of the slot allocator with oldest-stamp (FIFO) replacement.
// Usage:
//   s_* channel: one frame identifier per transaction (valid/ready).
//   m_* channel: one result per request: slot, hit, evicted_valid, evicted_frame.
//   A hit returns the owning slot and changes nothing. A miss takes the slot
//   with the smallest allocation stamp (lowest index on ties, so unused slots
//   go first), reports the displaced owner, and stamps the slot with the
//   running 32-bit counter, which then advances and wraps.
// Timing:
//   One slot is read and compared per cycle by a single compare unit. A request
//   passes through the slot scan, a drain state for the last registered read
//   and an update state, which loads the output registers. s_ready is high only
//   while idle, so a new request is accepted only after the previous result
//   has been taken.
// Reset (aresetn low, synchronous): all owner valid bits clear, stamp counter
//   returns to one, no result pending. No clearing pass is needed.
// Stall: a result waits in the output registers until m_ready; no new request
//   is accepted until it is taken.
module slot_allocator_oldest_stamp_top #(
    parameter int NUM_SLOTS  = soa_pkg::NUM_SLOTS_DEF,
    parameter int FRAME_BITS = soa_pkg::FRAME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [soa_pkg::FRAME_W-1:0]  s_frame_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [soa_pkg::SLOT_W-1:0]   m_slot,
    output logic                         m_hit,
    output logic                         m_evicted_valid,
    output logic [soa_pkg::FRAME_W-1:0]  m_evicted_frame
);
    import soa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // slot storage: tags and stamps in memories, valid bits in flops
    logic [FRAME_BITS-1:0] tag_mem   [NUM_SLOTS];
    logic [STAMP_W-1:0]    stamp_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  owner_vld_reg, owner_vld_next;

    soa_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [FRAME_BITS-1:0] key_reg, key_next;
    logic [STAMP_W-1:0]    stamp_cnt_reg, stamp_cnt_next;

    // registered read port
    logic [FRAME_BITS-1:0] rd_tag_reg;
    logic [STAMP_W-1:0]    rd_stamp_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_ok_reg;

    // output registers
    logic                  m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic                  hit_reg, hit_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [FRAME_BITS-1:0] ev_tag_reg, ev_tag_next;

    soa_scan_ctl_t         scan_ctl;
    logic                  found;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      best_idx;
    logic                  best_vld;
    logic [FRAME_BITS-1:0] best_tag;

    logic                  do_write;
    logic [FRAME_BITS+FRAME_W-1:0] id_ext;
    logic [FRAME_W+FRAME_BITS-1:0] ev_ext;
    logic [SLOT_W+IDX_W-1:0]       slot_ext;

    // only the low FRAME_BITS of the identifier are significant
    assign id_ext = {{FRAME_BITS{1'b0}}, s_frame_id};

    assign s_ready = (state_reg == ST_IDLE);

    assign scan_ctl.clear  = s_valid && s_ready;
    assign scan_ctl.sample = rd_ok_reg;

    soa_scan #(
        .NUM_SLOTS  (NUM_SLOTS),
        .FRAME_BITS (FRAME_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .rd_idx   (rd_idx_reg),
        .rd_vld   (rd_vld_reg),
        .rd_tag   (rd_tag_reg),
        .rd_stamp (rd_stamp_reg),
        .key      (key_reg),
        .found    (found),
        .hit_idx  (hit_idx),
        .best_idx (best_idx),
        .best_vld (best_vld),
        .best_tag (best_tag)
    );

    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        key_next       = key_reg;
        stamp_cnt_next = stamp_cnt_reg;
        owner_vld_next = owner_vld_reg;
        m_valid_next   = m_valid_reg;
        out_idx_next   = out_idx_reg;
        hit_next       = hit_reg;
        ev_vld_next    = ev_vld_reg;
        ev_tag_next    = ev_tag_reg;
        do_write       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next      = id_ext[FRAME_BITS-1:0];
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (found) begin
                    out_idx_next = hit_idx;
                    hit_next     = 1'b1;
                    ev_vld_next  = 1'b0;
                    ev_tag_next  = '0;
                end else begin
                    out_idx_next   = best_idx;
                    hit_next       = 1'b0;
                    ev_vld_next    = best_vld;
                    ev_tag_next    = best_vld ? best_tag : '0;
                    do_write       = 1'b1;
                    owner_vld_next[best_idx] = 1'b1;
                    stamp_cnt_next = stamp_cnt_reg + STAMP_INCR;
                end
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            owner_vld_reg <= '0;
            stamp_cnt_reg <= STAMP_RESET;
            m_valid_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            owner_vld_reg <= owner_vld_next;
            stamp_cnt_reg <= stamp_cnt_next;
            m_valid_reg   <= m_valid_next;
            rd_ok_reg     <= (state_reg == ST_SCAN);
        end
        scan_idx_reg <= scan_idx_next;
        key_reg      <= key_next;
        out_idx_reg  <= out_idx_next;
        hit_reg      <= hit_next;
        ev_vld_reg   <= ev_vld_next;
        ev_tag_reg   <= ev_tag_next;
    end

    // memory read port: one slot per scan cycle
    always_ff @(posedge aclk) begin
        rd_tag_reg   <= tag_mem[scan_idx_reg];
        rd_stamp_reg <= stamp_mem[scan_idx_reg];
        rd_vld_reg   <= owner_vld_reg[scan_idx_reg];
        rd_idx_reg   <= scan_idx_reg;
    end

    // memory write port: new owner on a miss
    always_ff @(posedge aclk) begin
        if (do_write) begin
            tag_mem[best_idx]   <= key_reg;
            stamp_mem[best_idx] <= stamp_cnt_reg;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, out_idx_reg};
    assign ev_ext   = {{FRAME_W{1'b0}}, ev_tag_reg};

    assign m_valid         = m_valid_reg;
    assign m_slot          = slot_ext[SLOT_W-1:0];
    assign m_hit           = hit_reg;
    assign m_evicted_valid = ev_vld_reg;
    assign m_evicted_frame = ev_ext[FRAME_W-1:0];

endmodule

FILE: rtl/core/soa_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
module soa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [soa_pkg::SLOT_W-1:0]   m_slot,
    input logic                         m_hit,
    input logic                         m_evicted_valid,
    input logic [soa_pkg::FRAME_W-1:0]  m_evicted_frame
);
    import soa_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_hit)
            && $stable(m_evicted_valid) && $stable(m_evicted_frame))
        else $error("result changed while stalled");

    // one transaction in flight: no intake while a result is pending
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("accepting while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready after accept");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted_valid)
        else $error("hit reports eviction");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> (m_evicted_frame == '0))
        else $error("evicted frame nonzero without eviction");

endmodule

bind slot_allocator_oldest_stamp_top soa_checker u_soa_checker (.*);

FILE: verif/tb_slot_allocator_oldest_stamp_top.sv
// Self-checking testbench for the oldest-stamp slot allocator top level.
`timescale 1ns / 100ps

module tb_slot_allocator_oldest_stamp_top;
    import soa_pkg::*;

    localparam int NSLOT        = NUM_SLOTS_DEF;
    localparam int LATENCY      = NSLOT + 2;    // sizes the final wait after the last result
    localparam int RANDOM_ITEMS = 1700;
    localparam int POOL_SIZE    = 24;           // a bit more ids than slots: hits and misses
    localparam int QUIET_LIMIT  = 4000;         // cycles with no handshake before giving up
    localparam int CALM_FIRST   = 700;          // random items in this span run without idling
    localparam int CALM_LAST    = 1000;
    localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'((64'd1 << FRAME_BITS_DEF) - 1);

    // One result transaction, field for field as on the m_ channel
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               ev_valid;
        logic [FRAME_W-1:0] ev_frame;
    } alloc_result_t;

    // Directed stimulus row: a fixed expectation is used where has_fixed is set,
    // otherwise the allocator model supplies it.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               has_fixed;
        alloc_result_t      res;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [FRAME_W-1:0] s_frame_id = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [SLOT_W-1:0]  m_slot;
    logic               m_hit;
    logic               m_evicted_valid;
    logic [FRAME_W-1:0] m_evicted_frame;

    // Allocator model state: owner tag, owner valid, allocation stamp per slot
    logic [FRAME_W-1:0] slot_owner [NSLOT];
    logic               slot_owned [NSLOT];
    logic [STAMP_W-1:0] slot_stamp [NSLOT];
    logic [STAMP_W-1:0] next_stamp;

    alloc_result_t      pending_allocs [$];   // results owed by the block, oldest first
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    bit                 calm_run = 1'b0;      // no source gaps and no sink stalls while set

    slot_allocator_oldest_stamp_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_id      (s_frame_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_frame (m_evicted_frame)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Directed part. Fill order is by index since all stamps start at zero;
    // hits leave stamps alone, so the replacement order stays first-in first-out.
    dir_row_t dir_rows [0:23] = '{
        '{16'h0000, 1'b1, '{4'd0,  1'b0, 1'b0, 16'h0000}},  // tag 0 at reset is not an owner
        '{16'h0000, 1'b1, '{4'd0,  1'b1, 1'b0, 16'h0000}},
        '{16'hFFFF, 1'b1, '{4'd1,  1'b0, 1'b0, 16'h0000}},
        '{16'hFFFF, 1'b1, '{4'd1,  1'b1, 1'b0, 16'h0000}},
        '{16'h0001, 1'b1, '{4'd2,  1'b0, 1'b0, 16'h0000}},
        '{16'h0002, 1'b1, '{4'd3,  1'b0, 1'b0, 16'h0000}},
        '{16'h0004, 1'b1, '{4'd4,  1'b0, 1'b0, 16'h0000}},
        '{16'h0008, 1'b1, '{4'd5,  1'b0, 1'b0, 16'h0000}},
        '{16'h0010, 1'b1, '{4'd6,  1'b0, 1'b0, 16'h0000}},
        '{16'h0020, 1'b1, '{4'd7,  1'b0, 1'b0, 16'h0000}},
        '{16'h0040, 1'b1, '{4'd8,  1'b0, 1'b0, 16'h0000}},
        '{16'h0080, 1'b1, '{4'd9,  1'b0, 1'b0, 16'h0000}},
        '{16'h0100, 1'b1, '{4'd10, 1'b0, 1'b0, 16'h0000}},
        '{16'h0200, 1'b1, '{4'd11, 1'b0, 1'b0, 16'h0000}},
        '{16'h0400, 1'b1, '{4'd12, 1'b0, 1'b0, 16'h0000}},
        '{16'h0800, 1'b1, '{4'd13, 1'b0, 1'b0, 16'h0000}},
        '{16'h1000, 1'b1, '{4'd14, 1'b0, 1'b0, 16'h0000}},
        '{16'h2000, 1'b1, '{4'd15, 1'b0, 1'b0, 16'h0000}},  // all slots owned now
        '{16'h8000, 1'b1, '{4'd0,  1'b0, 1'b1, 16'h0000}},  // evicts frame zero
        '{16'h4000, 1'b1, '{4'd1,  1'b0, 1'b1, 16'hFFFF}},
        '{16'hFFFF, 1'b1, '{4'd2,  1'b0, 1'b1, 16'h0001}},  // evicted frame comes back
        '{16'h8000, 1'b1, '{4'd0,  1'b1, 1'b0, 16'h0000}},  // hit must not refresh stamp
        '{16'h0001, 1'b0, '0},
        '{16'h0002, 1'b0, '0}
    };

    // Lookup first (lowest valid match), else replace the smallest stamp.
    function automatic alloc_result_t allocate_slot(input logic [FRAME_W-1:0] frame_in);
        alloc_result_t      res;
        logic [FRAME_W-1:0] tag;
        int                 owner;
        int                 oldest;
        tag   = frame_in & FRAME_MASK;
        owner = -1;
        res   = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (slot_owned[i] && slot_owner[i] == tag) owner = i;
        end
        if (owner >= 0) begin
            res.slot = SLOT_W'(owner);
            res.hit  = 1'b1;
        end else begin
            oldest = 0;
            for (int i = 1; i < NSLOT; i++) begin
                if (slot_stamp[i] < slot_stamp[oldest]) oldest = i;
            end
            if (slot_owned[oldest]) begin
                res.ev_valid = 1'b1;
                res.ev_frame = slot_owner[oldest];
            end
            slot_owner[oldest] = tag;
            slot_owned[oldest] = 1'b1;
            slot_stamp[oldest] = next_stamp;
            next_stamp         = next_stamp + STAMP_INCR;  // wraps at 2^32
            res.slot           = SLOT_W'(oldest);
        end
        return res;
    endfunction

    // Entered at a falling edge; returns at the falling edge after acceptance
    // with s_valid still high, so back-to-back transactions need no re-raise.
    task automatic send_frame(input logic [FRAME_W-1:0] fid, input logic has_fixed,
                              input alloc_result_t fixed_res);
        alloc_result_t predicted;
        int            gap;
        gap = 0;
        if (!calm_run && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 30);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_frame_id <= fid;
        do @(posedge aclk); while (!s_ready);
        predicted = allocate_slot(fid);
        pending_allocs.push_back(has_fixed ? fixed_res : predicted);
        @(negedge aclk);
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    // Sink: stalls about one cycle in five, except during the calm stretch
    always @(negedge aclk) begin
        m_ready <= calm_run || ($urandom_range(0, 99) >= 20);
    end

    // Result checker: every transaction taken on m_ is matched to the oldest owed result
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_allocs.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, slot %0h hit %0b", $time, m_slot,
                         m_hit);
            end else begin
                want = pending_allocs.pop_front();
                report_field("slot", 32'(want.slot), 32'(m_slot));
                report_field("hit", 32'(want.hit), 32'(m_hit));
                report_field("evicted_valid", 32'(want.ev_valid), 32'(m_evicted_valid));
                report_field("evicted_frame", 32'(want.ev_frame), 32'(m_evicted_frame));
            end
        end
    end

    // Watchdog on progress: any handshake on either side restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb_slot_allocator_oldest_stamp_top failed");
        $finish;
    end

    initial begin
        logic [FRAME_W-1:0] id_pool [POOL_SIZE];
        logic [FRAME_W-1:0] fid;
        for (int i = 0; i < NSLOT; i++) begin
            slot_owner[i] = '0;
            slot_owned[i] = 1'b0;
            slot_stamp[i] = '0;
        end
        next_stamp = STAMP_RESET;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r]) send_frame(dir_rows[r].frame, dir_rows[r].has_fixed,
                                         dir_rows[r].res);

        // Random part: mostly ids from a small working set so that hits, refills
        // and evictions of recently seen frames all happen; the rest is any id.
        foreach (id_pool[p]) id_pool[p] = FRAME_W'($urandom);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_run = (n >= CALM_FIRST && n < CALM_LAST);
            if ($urandom_range(0, 19) == 0)
                id_pool[$urandom_range(0, POOL_SIZE - 1)] = FRAME_W'($urandom);
            if ($urandom_range(0, 99) < 20) fid = FRAME_W'($urandom);
            else fid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_frame(fid, 1'b0, '0);
        end
        calm_run = 1'b0;
        s_valid <= 1'b0;

        while (pending_allocs.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_slot_allocator_oldest_stamp_top passed");
        end else begin
            $display("tb_slot_allocator_oldest_stamp_top failed");
        end
        $finish;
    end

endmodule
